/* rtl/hsvrgb_pkg.sv */
`default_nettype none

package hsvrgb_pkg;

  // common scale of the level arithmetic: 60 degrees times 255
  localparam logic [13:0] LEVEL_SCALE = 14'd15300;
  localparam logic [12:0] LEVEL_HALF  = 13'd7650;
  localparam logic [8:0]  HUE_TURN    = 9'd360;
  localparam logic [5:0]  SECTOR_DEG  = 6'd60;

  // v * factor + half stays below 2^22
  localparam int unsigned PROD_W = 22;

  // floor(x / 15300) = (x * RECIP) >> RECIP_SHIFT, exact for x < 2^22
  localparam int unsigned RECIP_W     = 23;
  localparam int unsigned RECIP_SHIFT = 36;
  localparam logic [RECIP_W-1:0] RECIP = 23'd4491470;
  localparam int unsigned QPROD_W = PROD_W + RECIP_W;

  // hue sector, 60 degrees each
  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

  // item after sector split
  typedef struct packed {
    sector_t    sector;
    logic [5:0] rem;
    logic [7:0] sat;
    logic [7:0] val;
    logic       grey;
  } hue_item_t;

  // item after level scaling
  typedef struct packed {
    sector_t    sector;
    logic [7:0] val;
    logic       grey;
    logic [7:0] lvl_p;
    logic [7:0] lvl_q;
    logic [7:0] lvl_t;
  } level_item_t;

endpackage

`default_nettype wire

/* rtl/hsvrgb_sector.sv */
`default_nettype none

module hsvrgb_sector import hsvrgb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       up_valid,
  output logic       up_ready,
  input  logic [8:0] hue,
  input  logic [7:0] sat,
  input  logic [7:0] val,
  output logic       dn_valid,
  input  logic       dn_ready,
  output hue_item_t  dn_item
);

  logic       s1_vld_r;
  logic [8:0] s1_h_r;
  logic [8:0] s1_h_nxt;
  logic [7:0] s1_sat_r;
  logic [7:0] s1_val_r;
  logic       s2_vld_r;
  hue_item_t  s2_item_r;
  hue_item_t  s2_item_nxt;
  logic       s1_rdy;
  logic       s2_rdy;

  // stage enables: a stage loads when empty or when its item moves on
  assign s2_rdy   = ~s2_vld_r | dn_ready;
  assign s1_rdy   = ~s1_vld_r | s2_rdy;
  assign up_ready = s1_rdy;

  // hue below 512, one subtract reduces it
  assign s1_h_nxt = (hue >= HUE_TURN) ? (hue - HUE_TURN) : hue;

  // sector and remainder by compare against the sector bounds
  always_comb begin
    s2_item_nxt.sat  = s1_sat_r;
    s2_item_nxt.val  = s1_val_r;
    s2_item_nxt.grey = (s1_sat_r == 8'd0);
    if (s1_h_r >= 9'd300) begin
      s2_item_nxt.sector = SEC_MAG_RED;
      s2_item_nxt.rem    = 6'(s1_h_r - 9'd300);
    end else if (s1_h_r >= 9'd240) begin
      s2_item_nxt.sector = SEC_BLU_MAG;
      s2_item_nxt.rem    = 6'(s1_h_r - 9'd240);
    end else if (s1_h_r >= 9'd180) begin
      s2_item_nxt.sector = SEC_CYN_BLU;
      s2_item_nxt.rem    = 6'(s1_h_r - 9'd180);
    end else if (s1_h_r >= 9'd120) begin
      s2_item_nxt.sector = SEC_GRN_CYN;
      s2_item_nxt.rem    = 6'(s1_h_r - 9'd120);
    end else if (s1_h_r >= 9'd60) begin
      s2_item_nxt.sector = SEC_YEL_GRN;
      s2_item_nxt.rem    = 6'(s1_h_r - 9'd60);
    end else begin
      s2_item_nxt.sector = SEC_RED_YEL;
      s2_item_nxt.rem    = s1_h_r[5:0];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      if (s1_rdy) s1_vld_r <= up_valid;
      if (s2_rdy) s2_vld_r <= s1_vld_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (s1_rdy && up_valid) begin
      s1_h_r   <= s1_h_nxt;
      s1_sat_r <= sat;
      s1_val_r <= val;
    end
    if (s2_rdy && s1_vld_r) begin
      s2_item_r <= s2_item_nxt;
    end
  end

  assign dn_valid = s2_vld_r;
  assign dn_item  = s2_item_r;

endmodule

`default_nettype wire

/* rtl/hsvrgb_level.sv */
`default_nettype none

module hsvrgb_level import hsvrgb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        up_valid,
  output logic        up_ready,
  input  hue_item_t   up_item,
  output logic        dn_valid,
  input  logic        dn_ready,
  output level_item_t dn_item
);

  logic              l1_vld_r;
  logic              l2_vld_r;
  logic              l3_vld_r;
  logic              l1_rdy;
  logic              l2_rdy;
  logic              l3_rdy;

  // stage 1: factors
  logic [13:0]       fp_r, fq_r, ft_r;
  logic [13:0]       fp_nxt, fq_nxt, ft_nxt;
  logic [5:0]        rem_inv;
  sector_t           l1_sec_r;
  logic [7:0]        l1_val_r;
  logic              l1_grey_r;

  // stage 2: scaled products with rounding offset
  logic [PROD_W-1:0] pp_r, pq_r, pt_r;
  logic [PROD_W-1:0] pp_nxt, pq_nxt, pt_nxt;
  sector_t           l2_sec_r;
  logic [7:0]        l2_val_r;
  logic              l2_grey_r;

  // stage 3: divide by the scale through the reciprocal
  logic [QPROD_W-1:0] qp, qq, qt;
  level_item_t       l3_item_r;

  assign l3_rdy   = ~l3_vld_r | dn_ready;
  assign l2_rdy   = ~l2_vld_r | l3_rdy;
  assign l1_rdy   = ~l1_vld_r | l2_rdy;
  assign up_ready = l1_rdy;

  assign rem_inv = SECTOR_DEG - up_item.rem;
  assign fp_nxt  = LEVEL_SCALE - (14'(SECTOR_DEG) * 14'(up_item.sat));
  assign fq_nxt  = LEVEL_SCALE - (14'(up_item.sat) * 14'(up_item.rem));
  assign ft_nxt  = LEVEL_SCALE - (14'(up_item.sat) * 14'(rem_inv));

  assign pp_nxt = PROD_W'(l1_val_r) * PROD_W'(fp_r) + PROD_W'(LEVEL_HALF);
  assign pq_nxt = PROD_W'(l1_val_r) * PROD_W'(fq_r) + PROD_W'(LEVEL_HALF);
  assign pt_nxt = PROD_W'(l1_val_r) * PROD_W'(ft_r) + PROD_W'(LEVEL_HALF);

  assign qp = QPROD_W'(pp_r) * QPROD_W'(RECIP);
  assign qq = QPROD_W'(pq_r) * QPROD_W'(RECIP);
  assign qt = QPROD_W'(pt_r) * QPROD_W'(RECIP);

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l1_vld_r <= 1'b0;
      l2_vld_r <= 1'b0;
      l3_vld_r <= 1'b0;
    end else begin
      if (l1_rdy) l1_vld_r <= up_valid;
      if (l2_rdy) l2_vld_r <= l1_vld_r;
      if (l3_rdy) l3_vld_r <= l2_vld_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (l1_rdy && up_valid) begin
      fp_r      <= fp_nxt;
      fq_r      <= fq_nxt;
      ft_r      <= ft_nxt;
      l1_sec_r  <= up_item.sector;
      l1_val_r  <= up_item.val;
      l1_grey_r <= up_item.grey;
    end
    if (l2_rdy && l1_vld_r) begin
      pp_r      <= pp_nxt;
      pq_r      <= pq_nxt;
      pt_r      <= pt_nxt;
      l2_sec_r  <= l1_sec_r;
      l2_val_r  <= l1_val_r;
      l2_grey_r <= l1_grey_r;
    end
    if (l3_rdy && l2_vld_r) begin
      l3_item_r.sector <= l2_sec_r;
      l3_item_r.val    <= l2_val_r;
      l3_item_r.grey   <= l2_grey_r;
      l3_item_r.lvl_p  <= qp[RECIP_SHIFT +: 8];
      l3_item_r.lvl_q  <= qq[RECIP_SHIFT +: 8];
      l3_item_r.lvl_t  <= qt[RECIP_SHIFT +: 8];
    end
  end

  assign dn_valid = l3_vld_r;
  assign dn_item  = l3_item_r;

endmodule

`default_nettype wire

/* rtl/hsv_to_rgb_pixel.sv */
// channel   | ports                                         | direction
// ----------+-----------------------------------------------+----------
// in        | in_valid, in_ready, in_hue[8:0],              | sink
//           | in_saturation[7:0], in_brightness[7:0]        |
// out       | out_valid, out_ready, out_red[7:0],           | source
//           | out_green[7:0], out_blue[7:0]                 |
//
// One item per cycle while out_ready is high; six register stages lie between
// the accepting edge and out_valid.
// Stages: hue wrap, sector split, factors, products, reciprocal divide,
// channel routing; the reciprocal multiply sets the longest path.
// Synchronous active-low reset clears the valid bits only.
// A low out_ready holds the output register; bubbles upstream still close.
`default_nettype none

module hsv_to_rgb_pixel import hsvrgb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [8:0] in_hue,
  input  logic [7:0] in_saturation,
  input  logic [7:0] in_brightness,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue
);

  logic        sec_valid;
  logic        sec_ready;
  hue_item_t   sec_item;
  logic        lvl_valid;
  logic        lvl_ready;
  level_item_t lvl_item;

  logic        out_vld_r;
  logic [7:0]  red_r, green_r, blue_r;
  logic [7:0]  red_nxt, green_nxt, blue_nxt;

  hsvrgb_sector u_sector (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .hue      (in_hue),
    .sat      (in_saturation),
    .val      (in_brightness),
    .dn_valid (sec_valid),
    .dn_ready (sec_ready),
    .dn_item  (sec_item)
  );

  hsvrgb_level u_level (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (sec_valid),
    .up_ready (sec_ready),
    .up_item  (sec_item),
    .dn_valid (lvl_valid),
    .dn_ready (lvl_ready),
    .dn_item  (lvl_item)
  );

  assign lvl_ready = ~out_vld_r | out_ready;

  // route levels to channels by sector
  always_comb begin
    red_nxt   = lvl_item.val;
    green_nxt = lvl_item.val;
    blue_nxt  = lvl_item.val;
    if (!lvl_item.grey) begin
      case (lvl_item.sector)
        SEC_RED_YEL: begin
          red_nxt = lvl_item.val;   green_nxt = lvl_item.lvl_t; blue_nxt = lvl_item.lvl_p;
        end
        SEC_YEL_GRN: begin
          red_nxt = lvl_item.lvl_q; green_nxt = lvl_item.val;   blue_nxt = lvl_item.lvl_p;
        end
        SEC_GRN_CYN: begin
          red_nxt = lvl_item.lvl_p; green_nxt = lvl_item.val;   blue_nxt = lvl_item.lvl_t;
        end
        SEC_CYN_BLU: begin
          red_nxt = lvl_item.lvl_p; green_nxt = lvl_item.lvl_q; blue_nxt = lvl_item.val;
        end
        SEC_BLU_MAG: begin
          red_nxt = lvl_item.lvl_t; green_nxt = lvl_item.lvl_p; blue_nxt = lvl_item.val;
        end
        default: begin
          red_nxt = lvl_item.val;   green_nxt = lvl_item.lvl_p; blue_nxt = lvl_item.lvl_q;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (lvl_ready) begin
      out_vld_r <= lvl_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (lvl_ready && lvl_valid) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

endmodule

`default_nettype wire

/* rtl/hsvrgb_checker.sv */
`default_nettype none

module hsvrgb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [8:0] in_hue,
  input logic [7:0] in_saturation,
  input logic [7:0] in_brightness,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue
);

  // nothing comes out straight after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result shown straight after reset");

  // a held result stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // with the sink ready throughout, an accepted item reaches the output register
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && out_ready) ##1 out_ready ##1 out_ready
      ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("item lost in the pipeline");

  // a grey pixel comes out at its brightness on all three channels
  a_grey: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(out_ready, 1) && $past(out_ready, 2) && $past(out_ready, 3)
      && $past(out_ready, 4) && $past(out_ready, 5)
      && $past(in_valid && in_ready, 6) && ($past(in_saturation, 6) == 8'd0)
      |-> (out_red == $past(in_brightness, 6)) && (out_green == $past(in_brightness, 6))
      && (out_blue == $past(in_brightness, 6)))
    else $error("grey pixel not passed through");

endmodule

bind hsv_to_rgb_pixel hsvrgb_checker u_hsvrgb_checker (.*);

`default_nettype wire

/* sim/tb_hsv_to_rgb_pixel.sv */
`default_nettype none

module tb_hsv_to_rgb_pixel import hsvrgb_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // independent copy of the conversion constants
  localparam int unsigned FULL_SCALE = 15300;
  localparam int unsigned HALF_SCALE = 7650;
  localparam int unsigned TURN_DEG   = 360;
  localparam int unsigned ARC_DEG    = 60;
  localparam int unsigned N_RANDOM   = 1200;
  localparam int unsigned DRAIN_CYC  = 12;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [8:0] in_hue;
  logic [7:0] in_saturation;
  logic [7:0] in_brightness;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;

  // tracks expected colours and compares the block's output against them
  class rgb_checker;
    rgb_t        rgb_due[$];
    int unsigned errors;
    int unsigned n_pixels;
    int unsigned n_colours;

    function new();
      errors = 0;
      n_pixels = 0;
      n_colours = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    // rounded v * factor / scale, half rounds up
    function int unsigned scale_level(int unsigned v, int unsigned factor);
      return (v * factor + HALF_SCALE) / FULL_SCALE;
    endfunction

    function rgb_t hsv_colour(logic [8:0] hue, logic [7:0] sat, logic [7:0] val);
      int unsigned h;
      int unsigned rem;
      int unsigned p;
      int unsigned q;
      int unsigned t;
      sector_t     sector;
      rgb_t        c;
      h = hue % TURN_DEG;
      if (sat == 8'd0) begin
        c.red = val;
        c.green = val;
        c.blue = val;
        return c;
      end
      sector = sector_t'(h / ARC_DEG);
      rem = h % ARC_DEG;
      p = scale_level(val, FULL_SCALE - ARC_DEG * sat);
      q = scale_level(val, FULL_SCALE - sat * rem);
      t = scale_level(val, FULL_SCALE - sat * (ARC_DEG - rem));
      // six-sector routing of v, p, q, t
      case (sector)
        SEC_RED_YEL: begin c.red = val;    c.green = t[7:0]; c.blue = p[7:0]; end
        SEC_YEL_GRN: begin c.red = q[7:0]; c.green = val;    c.blue = p[7:0]; end
        SEC_GRN_CYN: begin c.red = p[7:0]; c.green = val;    c.blue = t[7:0]; end
        SEC_CYN_BLU: begin c.red = p[7:0]; c.green = q[7:0]; c.blue = val;    end
        SEC_BLU_MAG: begin c.red = t[7:0]; c.green = p[7:0]; c.blue = val;    end
        default:     begin c.red = val;    c.green = p[7:0]; c.blue = q[7:0]; end
      endcase
      return c;
    endfunction

    function void note_pixel(logic [8:0] hue, logic [7:0] sat, logic [7:0] val);
      rgb_due.push_back(hsv_colour(hue, sat, val));
      n_pixels++;
    endfunction

    task check_colour(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      rgb_t want;
      if (rgb_due.size() == 0) begin
        report($sformatf("unexpected colour r=%0d g=%0d b=%0d", r, g, b));
      end else begin
        want = rgb_due.pop_front();
        n_colours++;
        if (r !== want.red)
          report($sformatf("colour %0d red %0d, want %0d", n_colours, r, want.red));
        if (g !== want.green)
          report($sformatf("colour %0d green %0d, want %0d", n_colours, g, want.green));
        if (b !== want.blue)
          report($sformatf("colour %0d blue %0d, want %0d", n_colours, b, want.blue));
      end
    endtask

    function int unsigned pending();
      return rgb_due.size();
    endfunction
  endclass

  rgb_checker chk;

  hsv_to_rgb_pixel dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_hue        (in_hue),
    .in_saturation (in_saturation),
    .in_brightness (in_brightness),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue)
  );

  always #1 clk = ~clk;

  // sample both handshakes at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        chk.note_pixel(in_hue, in_saturation, in_brightness);
      if (out_valid && out_ready)
        chk.check_colour(out_red, out_green, out_blue);
    end
  end

  // pixel sender: random gap per item, with stretches of back-to-back items
  int unsigned in_stretch = 0;
  bit          in_calm = 1'b0;

  task send_pixel(logic [8:0] hue, logic [7:0] sat, logic [7:0] val);
    int unsigned gap;
    if (in_stretch == 0) begin
      in_calm = ($urandom_range(0, 3) == 0);
      in_stretch = $urandom_range(8, 40);
    end
    in_stretch--;
    gap = in_calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_hue        <= hue;
    in_saturation <= sat;
    in_brightness <= val;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // draws an extreme now and then, otherwise anything in range
  function logic [7:0] pick_level();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 8'd0;
    if (roll == 1) return 8'd255;
    return 8'($urandom_range(0, 255));
  endfunction

  // result receiver: random stall before each item, with stall-free stretches
  initial begin
    int unsigned stall;
    int unsigned out_stretch;
    bit          out_calm;
    out_ready = 1'b0;
    out_stretch = 0;
    out_calm = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (out_stretch == 0) begin
        out_calm = ($urandom_range(0, 3) == 0);
        out_stretch = $urandom_range(8, 40);
      end
      out_stretch--;
      stall = out_calm ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // hard stop for a hung handshake
  initial begin
    #1ms;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    chk = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_hue = '0;
    in_saturation = '0;
    in_brightness = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // sector boundaries at full saturation and value
    send_pixel(9'd0,   8'd255, 8'd255);
    send_pixel(9'd59,  8'd255, 8'd255);
    send_pixel(9'd60,  8'd255, 8'd255);
    send_pixel(9'd119, 8'd255, 8'd255);
    send_pixel(9'd120, 8'd255, 8'd255);
    send_pixel(9'd179, 8'd255, 8'd255);
    send_pixel(9'd180, 8'd255, 8'd255);
    send_pixel(9'd239, 8'd255, 8'd255);
    send_pixel(9'd240, 8'd255, 8'd255);
    send_pixel(9'd299, 8'd255, 8'd255);
    send_pixel(9'd300, 8'd255, 8'd255);
    send_pixel(9'd359, 8'd255, 8'd255);
    // hues past a full turn wrap round
    send_pixel(9'd360, 8'd255, 8'd255);
    send_pixel(9'd400, 8'd200, 8'd180);
    send_pixel(9'd480, 8'd255, 8'd255);
    send_pixel(9'd511, 8'd255, 8'd255);
    send_pixel(9'd419, 8'd200, 8'd77);
    // grey pixels, black and near-grey
    send_pixel(9'd200, 8'd0,   8'd137);
    send_pixel(9'd511, 8'd0,   8'd255);
    send_pixel(9'd0,   8'd0,   8'd0);
    send_pixel(9'd90,  8'd255, 8'd0);
    send_pixel(9'd30,  8'd1,   8'd255);
    send_pixel(9'd30,  8'd255, 8'd128);
    send_pixel(9'd90,  8'd128, 8'd200);

    // random pixels
    for (int unsigned i = 0; i < N_RANDOM; i++)
      send_pixel(9'($urandom_range(0, 511)), pick_level(), pick_level());
    in_valid <= 1'b0;

    // drain, then let the pipeline settle
    while (chk.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (chk.pending() != 0)
      chk.report($sformatf("%0d colours never arrived", chk.pending()));

    $display("Converted %0d pixels and checked %0d colours: all six sectors,",
             chk.n_pixels, chk.n_colours);
    $display("grey pixels, wrapped hues and random stalls on both sides.");
    if (chk.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
rtl/hsvrgb_pkg.sv
rtl/hsvrgb_sector.sv
rtl/hsvrgb_level.sv
rtl/hsv_to_rgb_pixel.sv
rtl/hsvrgb_checker.sv
sim/tb_hsv_to_rgb_pixel.sv
